// File: hdl/ciil_pkg.sv
`timescale 1ns / 1ps
package ciil_pkg;
   localparam int MaxSamplesDefault = 1024;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      CSR_SAMPLE_STEP     = 2'd0,
      CSR_QUERY_START     = 2'd1,
      CSR_QUERY_INCREMENT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_BEFORE = 2'd0,
      REGION_INSIDE = 2'd1,
      REGION_END    = 2'd2
   } region_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_READ,
      ST_LD_MUL,
      ST_LD_ADD,
      ST_Q_READ,
      ST_Q_MUL1,
      ST_Q_MUL2,
      ST_Q_MUL3,
      ST_Q_SUM,
      ST_Q_STEP,
      ST_Q_ROUND,
      ST_Q_OUT
   } state_type;

   // classified work item handed from front to back
   typedef struct packed {
      logic              is_load;
      logic signed [15:0] sample;
      logic              last_sample;
      region_type        region;
      logic [31:0]       ip;
      logic [15:0]       frac;
   } work_type;

   localparam logic signed [47:0] Max48 = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] Min48 = {1'b1, {47{1'b0}}};
endpackage

// File: hdl/ciil_front.sv
`timescale 1ns / 1ps
// Front end: computes the query position and classifies each transaction,
// then pushes it into a short queue for the back end.
module ciil_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_opcode,
   input  logic signed [15:0]     req_sample,
   input  logic                   req_last_sample,
   input  logic [15:0]            req_query_index,
   input  logic signed [31:0]     query_start,
   input  logic signed [31:0]     query_increment,
   input  logic                   pop,
   output logic                   q_valid,
   output ciil_pkg::work_type     q_head
);
   // stage 1: register the item and the product k * increment
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_load_ff;
   logic signed [15:0]    s1_sample_ff;
   logic                  s1_last_ff;
   logic signed [48:0]    s1_prod_ff;
   logic signed [31:0]    s1_start_ff;

   // queue
   ciil_pkg::work_type    queue_ff [ciil_pkg::QueueDepth];
   logic [1:0]            count_ff, count_in;
   logic                  rd_ptr_ff, wr_ptr_ff;

   logic signed [49:0]    pos;
   ciil_pkg::work_type    item;
   logic                  push;
   logic                  accept;

   // stall input while stage 1 holds an item or the queue holds an item
   assign busy   = s1_valid_ff || (count_ff != 2'd0);
   assign accept = start && !busy;
   assign s1_valid_in = accept;
   assign push   = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_load_ff   <= !req_opcode;
         s1_sample_ff <= req_sample;
         s1_last_ff   <= req_last_sample;
         s1_prod_ff   <= $signed({1'b0, req_query_index}) * query_increment;
         s1_start_ff  <= query_start;
      end
   end

   // classification of the position; inside versus end is settled by the
   // back end against the sample count current when the item is taken
   always_comb begin
      pos = 50'(s1_prod_ff) + 50'(s1_start_ff);
      item.is_load     = s1_load_ff;
      item.sample      = s1_sample_ff;
      item.last_sample = s1_last_ff;
      item.frac        = pos[15:0];
      item.ip          = 32'(pos[47:16]);
      if (pos < 0) begin
         item.region = ciil_pkg::REGION_BEFORE;
      end else begin
         item.region = ciil_pkg::REGION_INSIDE;
      end
   end

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
      if (push) queue_ff[wr_ptr_ff] <= item;
   end

   assign q_valid = count_ff != 2'd0;
   assign q_head  = queue_ff[rd_ptr_ff];
endmodule

// File: hdl/ciil_back.sv
`timescale 1ns / 1ps
// Back end: executes loads and queries against the sample and integral
// memories with a small sequencer.
module ciil_back #(
   parameter int MaxSamples = 1024,
   parameter int CountWidth = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [15:0]               sample_step,
   input  logic                      q_valid,
   input  ciil_pkg::work_type        q_head,
   output logic                      pop,
   output logic                      rsp_valid,
   output logic signed [47:0]        rsp_integral,
   output logic [1:0]                rsp_region,
   output logic                      rsp_saturated
);
   localparam int AddrWidth = $clog2(MaxSamples);

   logic signed [15:0] sample_mem [MaxSamples];
   logic signed [47:0] integ_mem  [MaxSamples];

   ciil_pkg::state_type state_ff, state_in;
   ciil_pkg::work_type  cur_ff;
   ciil_pkg::work_type  head_item;
   logic [CountWidth-1:0] count_ff, ptr_ff;
   logic signed [47:0]  total_ff;

   logic signed [15:0]  y0_ff, y1_ff;
   logic signed [47:0]  i0_ff;
   logic signed [17:0]  sum_ff;
   logic signed [34:0]  p_ff;
   logic [31:0]         dd_ff;
   logic signed [33:0]  a_ff;
   logic signed [50:0]  ta_ff, tb_ff;
   logic signed [51:0]  t_ff;
   logic [51:0]         mag_ff;
   logic                neg_ff;
   logic [67:0]         prod_ff;
   logic                out_valid_ff;
   logic signed [47:0]  out_int_ff;
   logic [1:0]          out_reg_ff;
   logic                out_sat_ff;

   logic [AddrWidth-1:0] rd_addr0, rd_addr1;
   logic signed [15:0]   rd_y0_ff, rd_y1_ff;
   logic signed [47:0]   rd_i_ff;
   logic                 mem_we;
   logic [AddrWidth-1:0] wr_addr;
   logic signed [47:0]   wr_integ;
   logic                 do_pop;

   logic signed [49:0]   half_sum;
   logic signed [49:0]   wide_sum;
   logic [35:0]          round_mag;
   logic signed [49:0]   q_sum;

   assign pop = do_pop;

   // settle inside versus end against the current sample count
   always_comb begin
      head_item = q_head;
      if (q_head.region != ciil_pkg::REGION_BEFORE) begin
         if ({1'b0, q_head.ip} + 33'd1 >= 33'(count_ff)) begin
            head_item.region = ciil_pkg::REGION_END;
         end else begin
            head_item.region = ciil_pkg::REGION_INSIDE;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      do_pop   = 1'b0;
      unique case (state_ff)
         ciil_pkg::ST_IDLE: begin
            if (q_valid) begin
               do_pop = 1'b1;
               state_in = q_head.is_load ? ciil_pkg::ST_LD_READ : ciil_pkg::ST_Q_READ;
            end
         end
         ciil_pkg::ST_LD_READ:  state_in = ciil_pkg::ST_LD_MUL;
         ciil_pkg::ST_LD_MUL:   state_in = ciil_pkg::ST_LD_ADD;
         ciil_pkg::ST_LD_ADD:   state_in = ciil_pkg::ST_IDLE;
         ciil_pkg::ST_Q_READ:   state_in = ciil_pkg::ST_Q_MUL1;
         ciil_pkg::ST_Q_MUL1:   state_in = ciil_pkg::ST_Q_MUL2;
         ciil_pkg::ST_Q_MUL2:   state_in = ciil_pkg::ST_Q_MUL3;
         ciil_pkg::ST_Q_MUL3:   state_in = ciil_pkg::ST_Q_SUM;
         ciil_pkg::ST_Q_SUM:    state_in = ciil_pkg::ST_Q_STEP;
         ciil_pkg::ST_Q_STEP:   state_in = ciil_pkg::ST_Q_ROUND;
         ciil_pkg::ST_Q_ROUND:  state_in = ciil_pkg::ST_Q_OUT;
         ciil_pkg::ST_Q_OUT:    state_in = ciil_pkg::ST_IDLE;
         default:               state_in = ciil_pkg::ST_IDLE;
      endcase
   end

   // read addresses: loads read the previous sample; queries read ip, ip+1,
   // or the last entry when at the end or before the start
   always_comb begin
      if (head_item.is_load) begin
         rd_addr0 = AddrWidth'(ptr_ff - CountWidth'(1));
         rd_addr1 = rd_addr0;
      end else if (head_item.region == ciil_pkg::REGION_INSIDE) begin
         rd_addr0 = AddrWidth'(head_item.ip);
         rd_addr1 = AddrWidth'(head_item.ip + 32'd1);
      end else begin
         rd_addr0 = AddrWidth'(count_ff - CountWidth'(1));
         rd_addr1 = rd_addr0;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[wr_addr] <= cur_ff.sample;
         integ_mem[wr_addr]  <= wr_integ;
      end
      rd_y0_ff <= sample_mem[rd_addr0];
      rd_y1_ff <= sample_mem[rd_addr1];
      rd_i_ff  <= integ_mem[rd_addr0];
   end

   // load path arithmetic
   assign half_sum = (p_ff < 0)
      ? -50'((-50'(p_ff) + 50'd1) >>> 1)
      : 50'((50'(p_ff) + 50'd1) >>> 1);
   assign wide_sum = 50'(total_ff) + half_sum;
   assign mem_we   = (state_ff == ciil_pkg::ST_LD_ADD) && (ptr_ff < CountWidth'(MaxSamples));
   assign wr_addr  = AddrWidth'(ptr_ff);
   always_comb begin
      if (ptr_ff == '0) begin
         wr_integ = '0;
      end else if (wide_sum > 50'(ciil_pkg::Max48)) begin
         wr_integ = ciil_pkg::Max48;
      end else if (wide_sum < 50'(ciil_pkg::Min48)) begin
         wr_integ = ciil_pkg::Min48;
      end else begin
         wr_integ = 48'(wide_sum);
      end
   end

   // query rounding
   assign round_mag = 36'((prod_ff + (68'd1 << 32)) >> 33);
   assign q_sum = 50'(i0_ff) + (neg_ff ? -50'(round_mag) : 50'(round_mag));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ciil_pkg::ST_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= 1'b0;
         if (state_ff == ciil_pkg::ST_LD_ADD) begin
            if (mem_we) begin
               total_ff <= wr_integ;
            end
            if (cur_ff.last_sample) begin
               count_ff <= mem_we ? ptr_ff + CountWidth'(1) : ptr_ff;
               ptr_ff   <= '0;
            end else if (mem_we) begin
               ptr_ff <= ptr_ff + CountWidth'(1);
            end
         end
         if (state_ff == ciil_pkg::ST_Q_OUT) begin
            out_valid_ff <= 1'b1;
         end
      end
      if (do_pop) cur_ff <= head_item;

      // datapath registers
      unique case (state_ff)
         ciil_pkg::ST_LD_READ: begin
            sum_ff <= 18'(rd_y0_ff) + 18'(cur_ff.sample);
         end
         ciil_pkg::ST_LD_MUL: begin
            p_ff <= $signed({1'b0, sample_step}) * sum_ff;
         end
         ciil_pkg::ST_Q_READ: begin
            y0_ff <= rd_y0_ff;
            y1_ff <= rd_y1_ff;
            i0_ff <= rd_i_ff;
            dd_ff <= cur_ff.frac * cur_ff.frac;
         end
         ciil_pkg::ST_Q_MUL1: begin
            a_ff <= $signed({1'b0, cur_ff.frac, 17'd0}) - $signed({2'b0, dd_ff});
         end
         ciil_pkg::ST_Q_MUL2: begin
            ta_ff <= a_ff * y0_ff;
         end
         ciil_pkg::ST_Q_MUL3: begin
            tb_ff <= $signed({1'b0, dd_ff}) * y1_ff;
         end
         ciil_pkg::ST_Q_SUM: begin
            t_ff <= 52'(ta_ff) + 52'(tb_ff);
         end
         ciil_pkg::ST_Q_STEP: begin
            neg_ff <= t_ff < 0;
            mag_ff <= (t_ff < 0) ? 52'(-t_ff) : 52'(t_ff);
         end
         ciil_pkg::ST_Q_ROUND: begin
            prod_ff <= mag_ff * sample_step;
         end
         ciil_pkg::ST_Q_OUT: begin
            out_reg_ff <= cur_ff.region;
            out_sat_ff <= 1'b0;
            if (cur_ff.region == ciil_pkg::REGION_BEFORE) begin
               out_int_ff <= '0;
            end else if (cur_ff.region == ciil_pkg::REGION_END) begin
               out_int_ff <= (count_ff == '0) ? '0 : i0_ff;
            end else if (q_sum > 50'(ciil_pkg::Max48)) begin
               out_int_ff <= ciil_pkg::Max48;
               out_sat_ff <= 1'b1;
            end else if (q_sum < 50'(ciil_pkg::Min48)) begin
               out_int_ff <= ciil_pkg::Min48;
               out_sat_ff <= 1'b1;
            end else begin
               out_int_ff <= 48'(q_sum);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_integral  = out_int_ff;
   assign rsp_region    = out_reg_ff;
   assign rsp_saturated = out_sat_ff;
endmodule

// File: hdl/cumulative_integral_interpolated_lookup_top.sv
`timescale 1ns / 1ps
// A query passes the front position multiply stage, the queue and the
// eight-state back sequencer before it strobes rsp_valid; a load has no
// result and its store write lands in the sequencer's ST_LD_ADD state.
// The front takes a new transaction only once its stage 1 and its queue
// are empty; rsp_valid pulses for one cycle and the receiver cannot stall.
// Synchronous reset clears state, counts, pointers, valid flags and CSRs.
module cumulative_integral_interpolated_lookup_top #(
   parameter int MaxSamples = ciil_pkg::MaxSamplesDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic signed [15:0] req_sample,
   input  logic               req_last_sample,
   input  logic [15:0]        req_query_index,
   input  logic               req_last_query,
   output logic               rsp_valid,
   output logic signed [47:0] rsp_integral,
   output logic [1:0]         rsp_region,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   localparam int CountWidth = $clog2(MaxSamples + 1);

   logic [15:0]         step_ff;
   logic signed [31:0]  start_ff, incr_ff;
   logic                q_valid, pop, front_busy;
   ciil_pkg::work_type  q_head;
   logic                unused_last_query;

   assign csr_ready = 1'b1;
   assign unused_last_query = req_last_query;
   assign busy = front_busy || (unused_last_query && 1'b0);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 16'd4096;
         start_ff <= '0;
         incr_ff  <= 32'sd65536;
      end else if (csr_valid) begin
         unique case (csr_index)
            ciil_pkg::CSR_SAMPLE_STEP:     step_ff  <= csr_data[15:0];
            ciil_pkg::CSR_QUERY_START:     start_ff <= csr_data;
            ciil_pkg::CSR_QUERY_INCREMENT: incr_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   ciil_front u_front (
      .clock, .reset, .start, .busy(front_busy),
      .req_opcode, .req_sample, .req_last_sample, .req_query_index,
      .query_start(start_ff), .query_increment(incr_ff),
      .pop, .q_valid, .q_head
   );

   ciil_back #(.MaxSamples(MaxSamples), .CountWidth(CountWidth)) u_back (
      .clock, .reset, .sample_step(step_ff), .q_valid, .q_head, .pop,
      .rsp_valid, .rsp_integral, .rsp_region, .rsp_saturated
   );
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import ciil_pkg::*;

   localparam int  DepthLimit = 1024;
   localparam int  CycleLimit = 600000;
   localparam int  TargetItems = 650;
   localparam int  OpLoad = 0;
   localparam int  OpQuery = 1;
   localparam longint Hi48 = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint Lo48 = -64'sh0000_8000_0000_0000;

   typedef struct {
      logic signed [47:0] integral;
      region_type         region;
      logic               saturated;
   } lookup_result_t;

   typedef struct {
      bit                 opcode;
      logic signed [15:0] sample;
      bit                 last_sample;
      logic [15:0]        query_index;
      bit                 last_query;
      bit                 typed;
      logic signed [47:0] typed_integral;
      region_type         typed_region;
   } stim_row_t;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic req_opcode;
   logic signed [15:0] req_sample;
   logic req_last_sample;
   logic [15:0] req_query_index;
   logic req_last_query;
   logic rsp_valid;
   logic signed [47:0] rsp_integral;
   logic [1:0] rsp_region;
   logic rsp_saturated;
   logic csr_valid;
   logic csr_ready;
   csr_index_type csr_index;
   logic [31:0] csr_data;

   // predictor state
   logic signed [15:0] pr_samples [DepthLimit];
   longint             pr_integrals [DepthLimit];
   int                 pr_count;
   int                 pr_pointer;
   longint             pr_total;
   logic [15:0]        pr_step;
   logic signed [31:0] pr_start;
   logic signed [31:0] pr_increment;

   lookup_result_t expected_results [$];
   int     accepted_items;
   int     accepted_writes;
   int     items_sent;
   int     cycle_count;
   bit     failed;
   bit     typed_valid;
   lookup_result_t typed_result;
   stim_row_t directed_rows [$];

   cumulative_integral_interpolated_lookup_top i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint clamp48(input longint x, output bit clipped);
      clipped = 1'b0;
      if (x > Hi48) begin
         clipped = 1'b1;
         return Hi48;
      end
      if (x < Lo48) begin
         clipped = 1'b1;
         return Lo48;
      end
      return x;
   endfunction

   // one load transaction: trapezoid step, halved with rounding away from zero
   function automatic void integrate_sample(input logic signed [15:0] s, input bit last);
      longint p;
      longint half;
      bit     clipped;
      if (pr_pointer < DepthLimit) begin
         if (pr_pointer == 0) begin
            pr_total = 0;
         end else begin
            p = longint'(pr_step) * (longint'(pr_samples[pr_pointer - 1]) + longint'(s));
            half = (p < 0) ? -((-p + 1) >>> 1) : ((p + 1) >>> 1);
            pr_total = clamp48(pr_total + half, clipped);
         end
         pr_samples[pr_pointer] = s;
         pr_integrals[pr_pointer] = pr_total;
         pr_pointer++;
      end
      if (last) begin
         pr_count = pr_pointer;
         pr_pointer = 0;
      end
   endfunction

   // one query transaction: interpolated integral at start + k * increment
   function automatic lookup_result_t interpolate_integral(input logic [15:0] k);
      lookup_result_t res;
      longint pos;
      longint ip;
      longint d;
      longint dd;
      longint a;
      longint t;
      logic [127:0] mag;
      logic [127:0] prod;
      longint r;
      longint clamped;
      bit clipped;
      pos = longint'(pr_start) + longint'(k) * longint'(pr_increment);
      res.integral = '0;
      res.saturated = 1'b0;
      if (pos < 0) begin
         res.region = REGION_BEFORE;
      end else begin
         ip = pos >>> 16;
         if (ip >= longint'(pr_count) - 1) begin
            res.region = REGION_END;
            if (pr_count > 0) res.integral = pr_integrals[pr_count - 1][47:0];
         end else begin
            d = pos & 64'hFFFF;
            dd = d * d;
            a = d * 131072 - dd;
            t = a * longint'(pr_samples[ip]) + dd * longint'(pr_samples[ip + 1]);
            mag = (t < 0) ? 128'(-t) : 128'(t);
            prod = mag * 128'(pr_step);
            r = longint'((prod + (128'd1 << 32)) >> 33);
            if (t < 0) r = -r;
            res.region = REGION_INSIDE;
            clamped = clamp48(pr_integrals[ip] + r, clipped);
            res.integral = clamped[47:0];
            res.saturated = clipped;
         end
      end
      return res;
   endfunction

   // monitor: results first, then the transaction accepted at this edge
   always @(posedge clock) begin
      lookup_result_t exp_r;
      lookup_result_t pred;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: integral %0d region %0d", rsp_integral, rsp_region);
               failed = 1'b1;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_integral !== exp_r.integral) begin
                  $error("integral: expected %0d actual %0d", exp_r.integral, rsp_integral);
                  failed = 1'b1;
               end
               if (rsp_region !== exp_r.region) begin
                  $error("region: expected %0d actual %0d", exp_r.region, rsp_region);
                  failed = 1'b1;
               end
               if (rsp_saturated !== exp_r.saturated) begin
                  $error("saturated: expected %0d actual %0d", exp_r.saturated,
                         rsp_saturated);
                  failed = 1'b1;
               end
            end
         end
         if (start && !busy) begin
            if (req_opcode == OpLoad) begin
               integrate_sample(req_sample, req_last_sample);
            end else begin
               pred = interpolate_integral(req_query_index);
               expected_results.push_back(typed_valid ? typed_result : pred);
            end
            accepted_items++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SAMPLE_STEP:     pr_step = csr_data[15:0];
               CSR_QUERY_START:     pr_start = csr_data;
               CSR_QUERY_INCREMENT: pr_increment = csr_data;
               default: ;
            endcase
            accepted_writes++;
         end
      end
   end

   // timeout watchdog
   always @(negedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // random gap between bursts
   task automatic maybe_gap();
      int n;
      if ($urandom_range(0, 5) == 0) begin
         start = 1'b0;
         n = $urandom_range(1, 7);
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic send_item(input stim_row_t row);
      int seen;
      start = 1'b1;
      req_opcode = row.opcode;
      req_sample = row.sample;
      req_last_sample = row.last_sample;
      req_query_index = row.query_index;
      req_last_query = row.last_query;
      typed_valid = row.typed;
      typed_result.integral = row.typed_integral;
      typed_result.region = row.typed_region;
      typed_result.saturated = 1'b0;
      seen = accepted_items;
      do @(negedge clock); while (accepted_items == seen);
      typed_valid = 1'b0;
      items_sent++;
      maybe_gap();
   endtask

   task automatic send_load(input logic signed [15:0] s, input bit last);
      stim_row_t row;
      row = '{OpLoad, s, last, 16'($urandom), $urandom_range(0, 1), 0, 0, REGION_BEFORE};
      send_item(row);
   endtask

   task automatic send_query(input logic [15:0] k, input bit last);
      stim_row_t row;
      row = '{OpQuery, 16'($urandom), $urandom_range(0, 1), k, last, 0, 0, REGION_BEFORE};
      send_item(row);
   endtask

   // wait for the block to drain, then write a register
   task automatic write_register(input csr_index_type idx, input logic [31:0] value);
      int seen;
      start = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      seen = accepted_writes;
      do @(negedge clock); while (accepted_writes == seen);
      csr_valid = 1'b0;
   endtask

   function automatic logic [31:0] pick_position(input bit is_start);
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return is_start ? -$urandom_range(0, 3 * 65536) : 32'h0;
         3: return $urandom;
         default: return is_start ? $urandom_range(0, 24 * 65536)
                                  : $urandom_range(0, 3 * 65536) - 32'd32768;
      endcase
   endfunction

   initial begin
      int phase;
      int n;
      int m;
      logic [15:0] k;
      accepted_items = 0;
      accepted_writes = 0;
      items_sent = 0;
      cycle_count = 0;
      failed = 1'b0;
      typed_valid = 1'b0;
      typed_result = '{0, REGION_BEFORE, 0};
      pr_count = 0;
      pr_pointer = 0;
      pr_total = 0;
      pr_step = 16'd4096;
      pr_start = 0;
      pr_increment = 32'd65536;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = 1'b0;
      req_sample = '0;
      req_last_sample = 1'b0;
      req_query_index = '0;
      req_last_query = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_SAMPLE_STEP;
      csr_data = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // directed: empty array, single sample, extremes, full index range
      directed_rows = '{
         '{OpQuery, 0, 0, 16'd0, 0, 1, 0, REGION_END},
         '{OpLoad, 16'sd100, 1, 0, 0, 0, 0, REGION_BEFORE},
         '{OpQuery, 0, 0, 16'd0, 0, 1, 0, REGION_END},
         '{OpQuery, 0, 0, 16'hFFFF, 1, 1, 0, REGION_END},
         '{OpLoad, 16'sh7FFF, 0, 0, 0, 0, 0, REGION_BEFORE},
         '{OpLoad, -16'sh8000, 0, 0, 0, 0, 0, REGION_BEFORE},
         '{OpLoad, -16'sh8000, 0, 0, 0, 0, 0, REGION_BEFORE},
         '{OpLoad, 16'sh7FFF, 0, 0, 0, 0, 0, REGION_BEFORE},
         '{OpLoad, 16'sh7FFF, 0, 0, 0, 0, 0, REGION_BEFORE},
         '{OpLoad, -16'sd1, 1, 0, 0, 0, 0, REGION_BEFORE},
         '{OpQuery, 0, 0, 16'd0, 0, 1, 0, REGION_INSIDE},
         '{OpQuery, 0, 0, 16'd1, 0, 0, 0, REGION_BEFORE},
         '{OpQuery, 0, 0, 16'd2, 0, 0, 0, REGION_BEFORE},
         '{OpQuery, 0, 0, 16'd3, 0, 0, 0, REGION_BEFORE},
         '{OpQuery, 0, 0, 16'd4, 0, 0, 0, REGION_BEFORE},
         '{OpQuery, 0, 0, 16'd5, 0, 0, 0, REGION_BEFORE},
         '{OpQuery, 0, 0, 16'hFFFF, 1, 0, 0, REGION_BEFORE},
         '{OpLoad, 16'sd7, 0, 0, 0, 0, 0, REGION_BEFORE},
         '{OpQuery, 0, 0, 16'd2, 1, 0, 0, REGION_BEFORE}
      };
      foreach (directed_rows[i]) send_item(directed_rows[i]);
      send_load(16'sd9, 1'b1);

      // random phases: each with fresh settings, a well-formed load and queries
      phase = 0;
      while (items_sent < TargetItems) begin
         case (phase)
            0: write_register(CSR_SAMPLE_STEP, 32'd0);
            1: write_register(CSR_SAMPLE_STEP, 32'd65535);
            default: write_register(CSR_SAMPLE_STEP, $urandom_range(0, 65535));
         endcase
         write_register(CSR_QUERY_START, (phase == 1) ? 32'h8000_0000 : pick_position(1));
         write_register(CSR_QUERY_INCREMENT,
                        (phase == 1) ? 32'h7FFF_FFFF : pick_position(0));
         if ($urandom_range(0, 7) == 0) n = $urandom_range(1, 2);
         else n = $urandom_range(3, 40);
         for (int i = 0; i < n; i++) send_load(16'($urandom), i == n - 1);
         m = $urandom_range(5, 40);
         for (int i = 0; i < m; i++) begin
            // a load landing mid-query must not disturb the fixed count
            if ($urandom_range(0, 15) == 0) send_load(16'($urandom), 1'b0);
            k = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
            send_query(k, i == m - 1);
         end
         phase++;
      end

      start = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (!failed) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
